// File: hw/rtl/tdf_pkg.sv
// Shared types and constants of the transaction duplicate filter.
package tdf_pkg;

  // Field widths of one message.
  localparam int ADDR_W = 16;
  localparam int TID_W  = 8;
  localparam int TIME_W = 64;
  localparam int WIN_W  = 32;

  // Default table depth and window length after reset.
  localparam int               SLOTS_DEF    = 16;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd6000;

  // Lookup key of a message.
  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
  } key_t;

  // Scan record handed from cell to cell.
  typedef struct packed {
    logic              act;         // record carries a live lookup
    logic              hit;         // a valid entry matched all keys
    logic              dup;         // the match is still inside the window
    logic              free_found;  // a free, expired or matching slot was found
    logic [TIME_W-1:0] old_el;      // largest elapsed time seen so far
  } scan_t;

endpackage

// File: hw/rtl/transaction_duplicate_filter.sv
// Top level of the transaction duplicate filter: message register, control and slot chain.
// A new input word is accepted only in the idle state, after the previous lookup has left the
// slot chain; the lookup record walks the slot chain one cell per cycle, and the table write
// happens as the record leaves the last cell.
// A second result word can wait behind the output register; the input stalls while it does.
// Reset (rst_n low, synchronous) clears all slot valid bits and sets window_ms to 6000.
module transaction_duplicate_filter #(
  parameter int SLOTS = tdf_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [15:0] source_address, [31:16] destination_address,
  // [39:32] transaction_id, [103:40] now_ms
  input  logic [103:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [0] is_duplicate, [7:1] zero
  output logic [7:0]    out_tdata,
  input  logic          cfg_tvalid,
  output logic          cfg_tready,
  // [31:0] window_ms
  input  logic [31:0]   cfg_tdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          start_r;
  logic                          out_valid_r;
  logic                          out_dup_r;
  logic                          hold_valid_r;
  logic                          hold_dup_r;
  logic [tdf_pkg::WIN_W-1:0]     window_r;
  tdf_pkg::key_t                 key_r;
  logic [tdf_pkg::TIME_W-1:0]    now_r;

  tdf_pkg::scan_t                scan_w [SLOTS+1];
  logic [IW-1:0]                 free_w [SLOTS+1];
  logic [IW-1:0]                 old_w  [SLOTS+1];

  tdf_pkg::scan_t                tail;
  logic                          in_acc;
  logic                          out_stall;
  logic                          wr_en;
  logic [IW-1:0]                 wr_idx;

  assign in_tready  = (state_r == ST_IDLE) && !hold_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_stall  = out_valid_r && !out_tready;

  // Window register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= tdf_pkg::WINDOW_RESET;
    end else if (cfg_tvalid) begin
      window_r <= cfg_tdata;
    end
  end

  // Message fields held for the whole lookup.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r.src <= in_tdata[15:0];
      key_r.dst <= in_tdata[31:16];
      key_r.tid <= in_tdata[39:32];
      now_r     <= in_tdata[103:40];
    end
  end

  // Fresh lookup record entering the first cell.
  always_comb begin
    scan_w[0]            = '0;
    scan_w[0].act        = start_r;
    free_w[0]            = '0;
    old_w[0]             = '0;
  end

  // Slot chain.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tdf_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_in  (scan_w[i]),
      .free_in  (free_w[i]),
      .old_in   (old_w[i]),
      .key      (key_r),
      .now      (now_r),
      .window   (window_r),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .scan_out (scan_w[i+1]),
      .free_out (free_w[i+1]),
      .old_out  (old_w[i+1])
    );
  end

  // Table write as the record leaves the chain; a duplicate leaves the table alone.
  assign tail   = scan_w[SLOTS];
  assign wr_en  = tail.act && !(tail.hit && tail.dup);
  assign wr_idx = tail.free_found ? free_w[SLOTS] : old_w[SLOTS];

  // Control sequencing.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (tail.act) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A verdict that finds the output word still waiting goes to the hold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      if (tail.act) begin
        if (out_stall) begin
          hold_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_valid_r && out_tready) begin
        out_valid_r  <= hold_valid_r;
        hold_valid_r <= 1'b0;
      end
    end
  end

  // Result words.
  always_ff @(posedge clk) begin
    if (tail.act) begin
      if (out_stall) begin
        hold_dup_r <= tail.hit && tail.dup;
      end else begin
        out_dup_r <= tail.hit && tail.dup;
      end
    end else if (out_valid_r && out_tready && hold_valid_r) begin
      out_dup_r <= hold_dup_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_dup_r};

endmodule

// File: hw/rtl/tdf_cell.sv
// One table slot of the duplicate filter and its stage of the scan chain.
module tdf_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tdf_pkg::scan_t                  scan_in,
  input  logic [IW-1:0]                   free_in,
  input  logic [IW-1:0]                   old_in,
  input  tdf_pkg::key_t                   key,
  input  logic [tdf_pkg::TIME_W-1:0]      now,
  input  logic [tdf_pkg::WIN_W-1:0]       window,
  input  logic                            wr_en,
  input  logic [IW-1:0]                   wr_idx,
  output tdf_pkg::scan_t                  scan_out,
  output logic [IW-1:0]                   free_out,
  output logic [IW-1:0]                   old_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                          valid_r;
  tdf_pkg::key_t                 key_r;
  logic [tdf_pkg::TIME_W-1:0]    seen_r;

  tdf_pkg::scan_t                scan_r, scan_nxt;
  logic [IW-1:0]                 free_r, free_nxt;
  logic [IW-1:0]                 old_r, old_nxt;

  logic [tdf_pkg::TIME_W-1:0]    elapsed;
  logic                          expired;
  logic                          sel;

  assign elapsed = now - seen_r;
  assign expired = elapsed >= {{(tdf_pkg::TIME_W - tdf_pkg::WIN_W){1'b0}}, window};
  assign sel     = wr_en && (wr_idx == MY_IDX);

  // Update the scan record with this slot's verdict.
  always_comb begin
    scan_nxt = scan_in;
    free_nxt = free_in;
    old_nxt  = old_in;
    if (scan_in.act && !scan_in.hit) begin
      if (!valid_r) begin
        if (!scan_in.free_found) begin
          scan_nxt.free_found = 1'b1;
          free_nxt            = MY_IDX;
        end
      end else if (key_r == key) begin
        // A match ends the lookup; its slot becomes the write target.
        scan_nxt.hit        = 1'b1;
        scan_nxt.dup        = !expired;
        scan_nxt.free_found = 1'b1;
        free_nxt            = MY_IDX;
      end else begin
        if (expired && !scan_in.free_found) begin
          scan_nxt.free_found = 1'b1;
          free_nxt            = MY_IDX;
        end
        if (elapsed > scan_in.old_el) begin
          scan_nxt.old_el = elapsed;
          old_nxt         = MY_IDX;
        end
      end
    end
  end

  // Record leaving this stage; only the live flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.act <= 1'b0;
    end else begin
      scan_r.act <= scan_nxt.act;
    end
    scan_r.hit        <= scan_nxt.hit;
    scan_r.dup        <= scan_nxt.dup;
    scan_r.free_found <= scan_nxt.free_found;
    scan_r.old_el     <= scan_nxt.old_el;
    free_r            <= free_nxt;
    old_r             <= old_nxt;
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (sel) begin
      key_r  <= key;
      seen_r <= now;
    end
  end

  assign scan_out = scan_r;
  assign free_out = free_r;
  assign old_out  = old_r;

endmodule
